FILE: design/tone_sequence_player_core_defines.svh
// assertion macros for the tone sequence player
`ifndef TONE_SEQUENCE_PLAYER_CORE_DEFINES_SVH
`define TONE_SEQUENCE_PLAYER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone sequence player: same-cycle check failed");
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone sequence player: next-cycle check failed");
`else
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tsp_pkg.sv
// constants and types shared by the tone sequence player files
package tsp_pkg;

    localparam int STORE_DEPTH  = 20;
    localparam int SHADOW_DEPTH = 3;
    localparam int RAM_DEPTH    = STORE_DEPTH - SHADOW_DEPTH;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int SH_AW        = $clog2(SHADOW_DEPTH);
    localparam int POS_W        = $clog2(STORE_DEPTH + 2);

    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [7:0]       byte_t;
    typedef logic [RAM_AW-1:0] ram_addr_t;
    typedef logic [SHADOW_DEPTH-1:0][7:0] shadow_t;

    localparam pos_t DEPTH_POS  = POS_W'(STORE_DEPTH);
    localparam pos_t LAST_POS   = POS_W'(STORE_DEPTH - 1);
    localparam pos_t SHADOW_POS = POS_W'(SHADOW_DEPTH);

    localparam byte_t END_CODE  = 8'd0;
    localparam byte_t REST_CODE = 8'd255;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;
    localparam logic [1:0] CMD_SINGLE = 2'd3;

endpackage

FILE: design/tsp_ram.sv
// generic dual read port ram with registered read data
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: design/tone_sequence_player_core.sv
// tone sequence player: note store, playback sequencer and pwm value output
//
// usage:
//   s_ channel carries one request per beat: s_tuser is the command (tick,
//   write byte, start, single note), s_tdata the slot, byte and hold ticks.
//   m_ channel returns one result per request: pwm top, compare and playing.
//   cfg_ channel writes the sound enable bit; cfg_ready is always high and
//   writes are expected only while no request is in flight.
// order: an accepted request is registered in the pending stage, then moves
//   to the output register, from which it is presented on m_.
// throughput: one request per cycle while s_tready is high; the store is read
//   ahead at the next play position through the two registered ram read ports,
//   so each tick sees its note and hold bytes at once.
// reset: store reads as end code, position, hold and pwm values are zero,
//   sound enable is one; no clearing pass is needed.
// stall: a finished result waits in the output register while one more
//   request is taken into the pending stage; s_tready drops only when both
//   are full and m_tready is low.
`include "tone_sequence_player_core_defines.svh"

module tone_sequence_player_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot [4:0], byte_value [12:5], hold_ticks [20:13], zero pad [23:21]
    input  logic [tsp_pkg::S_DATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [tsp_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // period_top [7:0], duty_compare [14:8], playing [15]
    output logic [tsp_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    import tsp_pkg::*;

    // effective store read: shadow entries, ram with bypass, end for unwritten entries and past the store
    function automatic byte_t eff_read(input pos_t pos, input logic fwd,
                                       input byte_t fwd_data, input byte_t ram_q,
                                       input shadow_t shadow,
                                       input logic [RAM_DEPTH-1:0] valid);
        ram_addr_t idx;
        byte_t     res;
        idx = RAM_AW'(pos - SHADOW_POS);
        if (pos >= DEPTH_POS) begin
            res = END_CODE;
        end else if (pos < SHADOW_POS) begin
            res = shadow[pos[SH_AW-1:0]];
        end else if (fwd) begin
            res = fwd_data;
        end else if (!valid[idx]) begin
            res = END_CODE;
        end else begin
            res = ram_q;
        end
        return res;
    endfunction

    function automatic ram_addr_t ram_index(input pos_t pos);
        ram_addr_t idx;
        idx = '0;
        if (pos >= SHADOW_POS && pos < DEPTH_POS) begin
            idx = RAM_AW'(pos - SHADOW_POS);
        end
        return idx;
    endfunction

    logic                 en_reg;
    pos_t                 rp_reg, rp_next;
    byte_t                hold_reg, hold_next;
    byte_t                top_reg, top_next;
    logic [6:0]           cmp_reg, cmp_next;
    shadow_t              shadow_reg, shadow_next;
    logic [RAM_DEPTH-1:0] valid_reg, valid_next;
    pos_t                 ra0_reg, ra1_reg, ra0_next, ra1_next;
    logic                 fwd0_reg, fwd1_reg, fwd0_next, fwd1_next;
    byte_t                fwd_data_reg;

    logic                 pend_valid_reg, pend_valid_next;
    byte_t                pend_top_reg;
    logic [6:0]           pend_cmp_reg;
    logic                 pend_hold_nz_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic       accept, pend_move, playing;
    logic [1:0] cmd;
    logic [4:0] slot;
    byte_t      byte_in, hold_in;
    byte_t      ram_q0, ram_q1, rd0, rd1;
    pos_t       rp1, rp2, start_pos;
    logic       st_we, ram_we;
    pos_t       st_pos;
    byte_t      st_data;
    ram_addr_t  ram_waddr;

    assign cmd     = s_tuser;
    assign slot    = s_tdata[4:0];
    assign byte_in = s_tdata[12:5];
    assign hold_in = s_tdata[20:13];

    assign cfg_ready = 1'b1;
    assign pend_move = pend_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign rd0 = eff_read(ra0_reg, fwd0_reg, fwd_data_reg, ram_q0, shadow_reg, valid_reg);
    assign rd1 = eff_read(ra1_reg, fwd1_reg, fwd_data_reg, ram_q1, shadow_reg, valid_reg);

    // rd0 already reflects the request now pending
    assign playing = pend_hold_nz_reg || (rd0 != END_CODE);

    assign rp1 = rp_reg + 1'b1;
    assign rp2 = (rp1 < DEPTH_POS) ? rp1 + 1'b1 : rp1;

    always_comb begin
        start_pos = '0;
        if (en_reg) begin
            if (32'(slot) > 32'(STORE_DEPTH - 1)) begin
                start_pos = LAST_POS;
            end else begin
                start_pos = POS_W'(slot);
            end
        end
    end

    always_comb begin
        rp_next     = rp_reg;
        hold_next   = hold_reg;
        top_next    = top_reg;
        cmp_next    = cmp_reg;
        shadow_next = shadow_reg;
        valid_next  = valid_reg;
        st_we       = 1'b0;
        st_pos      = '0;
        st_data     = END_CODE;
        ram_we      = 1'b0;
        if (accept) begin
            case (cmd)
                CMD_TICK: begin
                    if (hold_reg != 8'd0) begin
                        hold_next = hold_reg - 8'd1;
                    end else if (rd0 == END_CODE) begin
                        top_next = 8'd0;
                        cmp_next = 7'd0;
                    end else begin
                        rp_next   = rp2;
                        hold_next = rd1;
                        if (rd0 == REST_CODE) begin
                            top_next = 8'd0;
                            cmp_next = 7'd0;
                        end else begin
                            top_next = rd0;
                            cmp_next = rd0[7:1];
                        end
                    end
                end
                CMD_WRITE: begin
                    if (32'(slot) < 32'(STORE_DEPTH)) begin
                        st_we   = 1'b1;
                        st_pos  = POS_W'(slot);
                        st_data = byte_in;
                    end
                end
                CMD_START: begin
                    st_we     = 1'b1;
                    st_pos    = start_pos;
                    st_data   = END_CODE;
                    rp_next   = '0;
                    hold_next = 8'd0;
                end
                CMD_SINGLE: begin
                    if (en_reg) begin
                        shadow_next = {END_CODE, hold_in, byte_in};
                        rp_next     = '0;
                        hold_next   = 8'd0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (st_we) begin
            if (st_pos < SHADOW_POS) begin
                shadow_next[st_pos[SH_AW-1:0]] = st_data;
            end else begin
                ram_we = 1'b1;
                valid_next[ram_index(st_pos)] = 1'b1;
            end
        end
    end

    assign ram_waddr = ram_index(st_pos);

    // read ahead at the position the next request will see
    assign ra0_next  = rp_next;
    assign ra1_next  = rp_next + 1'b1;
    assign fwd0_next = ram_we && (st_pos == ra0_next);
    assign fwd1_next = ram_we && (st_pos == ra1_next);

    assign pend_valid_next = accept ? 1'b1 : (pend_move ? 1'b0 : pend_valid_reg);
    assign m_tvalid_next   = pend_move ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    tsp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (st_data),
        .raddr_a (ram_index(ra0_next)),
        .raddr_b (ram_index(ra1_next)),
        .rdata_a (ram_q0),
        .rdata_b (ram_q1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg         <= 1'b1;
            rp_reg         <= '0;
            hold_reg       <= 8'd0;
            top_reg        <= 8'd0;
            cmp_reg        <= 7'd0;
            shadow_reg     <= {SHADOW_DEPTH{END_CODE}};
            valid_reg      <= '0;
            ra0_reg        <= '0;
            ra1_reg        <= pos_t'(1);
            fwd0_reg       <= 1'b0;
            fwd1_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                en_reg <= cfg_data;
            end
            rp_reg         <= rp_next;
            hold_reg       <= hold_next;
            top_reg        <= top_next;
            cmp_reg        <= cmp_next;
            shadow_reg     <= shadow_next;
            valid_reg      <= valid_next;
            ra0_reg        <= ra0_next;
            ra1_reg        <= ra1_next;
            fwd0_reg       <= fwd0_next;
            fwd1_reg       <= fwd1_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= st_data;
        if (accept) begin
            pend_top_reg     <= top_next;
            pend_cmp_reg     <= cmp_next;
            pend_hold_nz_reg <= (hold_next != 8'd0);
        end
        if (pend_move) begin
            m_tdata_reg <= {playing, pend_cmp_reg, pend_top_reg};
        end
    end

    `TSP_ASSERT_NOW(a_pos_in_range, aclk, aresetn, 1'b1, rp_reg <= DEPTH_POS)
    `TSP_ASSERT_NOW(a_duty_half_top, aclk, aresetn, m_tvalid_reg, m_tdata_reg[14:8] == m_tdata_reg[7:1])
    `TSP_ASSERT_NEXT(a_pend_refills_out, aclk, aresetn, pend_valid_reg && (!m_tvalid_reg || m_tready), m_tvalid_reg)
    `TSP_ASSERT_NEXT(a_pend_held, aclk, aresetn, pend_valid_reg && m_tvalid_reg && !m_tready, pend_valid_reg && $stable(pend_top_reg))
    `TSP_ASSERT_NEXT(a_fetch_advances, aclk, aresetn, accept && (cmd == CMD_TICK) && (hold_reg == 8'd0) && (rd0 != END_CODE), rp_reg != $past(rp_reg))

endmodule
